### hw/rtl/buddy_block_allocator_top_macros.svh
// Assertion macros shared by the buddy allocator RTL.
// Included by the files that carry concurrent checks; depends on clk and rst_n.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/bba_pkg.sv
// Types, constants and helper functions of the buddy block allocator.
// Used by the engine and the top level; depends on nothing.
package bba_pkg;

  localparam int PAGE_BITS  = 12;
  localparam int POOL_BITS  = 20;
  localparam int PG_W       = POOL_BITS - PAGE_BITS;
  localparam int NUM_PAGES  = 1 << PG_W;
  localparam int NUM_ORDERS = PG_W + 1;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int LINK_W     = PG_W + 1;
  localparam int ORD_W      = $clog2(NUM_ORDERS + 1);
  localparam int SIZE_W     = 21;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

  // Field selectors of a read-modify-write on the link memory.
  localparam logic [1:0] FLD_NEXT  = 2'd0;
  localparam logic [1:0] FLD_PREV  = 2'd1;
  localparam logic [1:0] FLD_ORDER = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [SIZE_W-1:0]   request_size;
    logic [POOL_BITS-1:0] block_offset;
  } bba_req_t;

  typedef struct packed {
    logic [POOL_BITS-1:0] result_offset;
    logic                 status;
  } bba_rsp_t;

  // One link memory word per page.
  typedef struct packed {
    logic              on_list;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } bba_word_t;

  // Smallest relative order whose block holds the size; NUM_ORDERS if none.
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] res;
    res = ORD_W'(NUM_ORDERS);
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if (((SIZE_W + 1)'(1) << (PAGE_BITS + k)) >= {1'b0, size}) begin
        res = ORD_W'(k);
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the page link memory; no dependencies.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bba_engine.sv
// Sequencer of the buddy allocator: free-list heads, link memory and its valid bits.
// Depends on bba_pkg, bba_ram and the assertion macro header.
`include "buddy_block_allocator_top_macros.svh"
module bba_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_req_t req,
  input  logic              out_free,
  output logic              done,
  output bba_pkg::bba_rsp_t rsp
);
  import bba_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A_SEL   = 5'd1;
  localparam logic [4:0] S_A_SPLIT = 5'd2;
  localparam logic [4:0] S_A_FIN   = 5'd3;
  localparam logic [4:0] S_F_START = 5'd4;
  localparam logic [4:0] S_F_RD    = 5'd5;
  localparam logic [4:0] S_F_RDW   = 5'd6;
  localparam logic [4:0] S_F_LOOP  = 5'd7;
  localparam logic [4:0] S_F_BUD   = 5'd8;
  localparam logic [4:0] S_F_MERGE = 5'd9;
  localparam logic [4:0] S_F_FIN   = 5'd10;
  localparam logic [4:0] S_U_RD    = 5'd11;
  localparam logic [4:0] S_U_W     = 5'd12;
  localparam logic [4:0] S_U_P     = 5'd13;
  localparam logic [4:0] S_U_N     = 5'd14;
  localparam logic [4:0] S_U_CLR   = 5'd15;
  localparam logic [4:0] S_P_WR    = 5'd16;
  localparam logic [4:0] S_P_H     = 5'd17;
  localparam logic [4:0] S_M_RD    = 5'd18;
  localparam logic [4:0] S_M_WR    = 5'd19;
  localparam logic [4:0] S_DONE    = 5'd20;

  logic [4:0]        state_r, state_nxt;
  logic [ORD_W-1:0]  req_r, req_nxt;
  logic [PG_W-1:0]   pg_r, pg_nxt;
  logic [ORD_W-1:0]  ord_r, ord_nxt;
  logic [PG_W-1:0]   bud_r, bud_nxt;
  logic [PG_W-1:0]   uaddr_r, uaddr_nxt;
  logic [LINK_W-1:0] up_r, up_nxt;
  logic [LINK_W-1:0] un_r, un_nxt;
  logic [ORD_W-1:0]  uord_r, uord_nxt;
  logic [4:0]        uret_r, uret_nxt;
  logic [PG_W-1:0]   paddr_r, paddr_nxt;
  logic [ORD_W-1:0]  pord_r, pord_nxt;
  logic [LINK_W-1:0] ph_r, ph_nxt;
  logic [4:0]        pret_r, pret_nxt;
  logic [PG_W-1:0]   maddr_r, maddr_nxt;
  logic [1:0]        mfld_r, mfld_nxt;
  logic [LINK_W-1:0] mval_r, mval_nxt;
  logic [4:0]        mret_r, mret_nxt;
  logic [LINK_W-1:0] head_r [NUM_ORDERS];
  logic [LINK_W-1:0] head_nxt [NUM_ORDERS];
  bba_rsp_t          rsp_r, rsp_nxt;

  logic [NUM_PAGES-1:0] valid_r;
  logic                 rd_valid_r;
  logic                 rd_zero_r;
  logic                 ram_we;
  logic [PG_W-1:0]      ram_waddr;
  bba_word_t            ram_wdata;
  logic [PG_W-1:0]      ram_raddr;
  bba_word_t            ram_rdata;
  bba_word_t            rword;
  bba_word_t            dflt_word;
  bba_word_t            mword;
  logic [PG_W-1:0]      bud_c;

  bba_ram #(
    .WIDTH ($bits(bba_word_t)),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A page never written reads as its reset word; page 0 starts as the whole pool.
  always_comb begin
    dflt_word.on_list = rd_zero_r;
    dflt_word.ord     = rd_zero_r ? ORD_W'(TOP_ORDER) : '0;
    dflt_word.prev    = NIL;
    dflt_word.next    = NIL;
    rword = rd_valid_r ? ram_rdata : dflt_word;
  end

  // Merged result of a read-modify-write.
  always_comb begin
    mword = rword;
    case (mfld_r)
      FLD_NEXT: mword.next = mval_r;
      FLD_PREV: mword.prev = mval_r;
      default:  mword.ord  = mval_r[ORD_W-1:0];
    endcase
  end

  assign bud_c    = pg_r ^ (PG_W'(1) << ord_r);
  assign in_ready = (state_r == S_IDLE);
  assign rsp      = rsp_r;

  // Sequencer: each state does at most one link memory access.
  always_comb begin
    logic             found;
    logic [ORD_W-1:0] k_sel;
    found       = 1'b0;
    k_sel       = '0;
    state_nxt   = state_r;
    req_nxt     = req_r;
    pg_nxt      = pg_r;
    ord_nxt     = ord_r;
    bud_nxt     = bud_r;
    uaddr_nxt   = uaddr_r;
    up_nxt      = up_r;
    un_nxt      = un_r;
    uord_nxt    = uord_r;
    uret_nxt    = uret_r;
    paddr_nxt   = paddr_r;
    pord_nxt    = pord_r;
    ph_nxt      = ph_r;
    pret_nxt    = pret_r;
    maddr_nxt   = maddr_r;
    mfld_nxt    = mfld_r;
    mval_nxt    = mval_r;
    mret_nxt    = mret_r;
    head_nxt    = head_r;
    rsp_nxt     = rsp_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    done        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = size_order(req.request_size);
          pg_nxt    = req.block_offset[POOL_BITS-1:PAGE_BITS];
          state_nxt = req.operation ? S_F_START : S_A_SEL;
        end
      end
      S_A_SEL: begin
        for (int k = 0; k < NUM_ORDERS; k++) begin
          if (!found && (ORD_W'(k) >= req_r) && (head_r[k] != NIL)) begin
            found = 1'b1;
            k_sel = ORD_W'(k);
          end
        end
        if (!found) begin
          rsp_nxt.result_offset = '0;
          rsp_nxt.status        = 1'b1;
          state_nxt             = S_DONE;
        end else begin
          pg_nxt    = head_r[k_sel][PG_W-1:0];
          ord_nxt   = k_sel;
          uaddr_nxt = head_r[k_sel][PG_W-1:0];
          uret_nxt  = S_A_SPLIT;
          state_nxt = S_U_RD;
        end
      end
      S_A_SPLIT: begin
        // Push each right half, from the largest down to the wanted order.
        if (ord_r > req_r) begin
          paddr_nxt = pg_r ^ (PG_W'(1) << (ord_r - ORD_W'(1)));
          pord_nxt  = ord_r - ORD_W'(1);
          ord_nxt   = ord_r - ORD_W'(1);
          pret_nxt  = S_A_SPLIT;
          state_nxt = S_P_WR;
        end else begin
          maddr_nxt = pg_r;
          mfld_nxt  = FLD_ORDER;
          mval_nxt  = LINK_W'(req_r);
          mret_nxt  = S_A_FIN;
          state_nxt = S_M_RD;
        end
      end
      S_A_FIN: begin
        rsp_nxt.result_offset = {pg_r, {PAGE_BITS{1'b0}}};
        rsp_nxt.status        = 1'b0;
        state_nxt             = S_DONE;
      end
      S_F_START: begin
        uaddr_nxt = pg_r;
        uret_nxt  = S_F_RD;
        state_nxt = S_U_RD;
      end
      S_F_RD: begin
        ram_raddr = pg_r;
        state_nxt = S_F_RDW;
      end
      S_F_RDW: begin
        ord_nxt   = (rword.ord > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : rword.ord;
        state_nxt = S_F_LOOP;
      end
      S_F_LOOP: begin
        if (ord_r < ORD_W'(TOP_ORDER)) begin
          bud_nxt   = bud_c;
          ram_raddr = bud_c;
          state_nxt = S_F_BUD;
        end else begin
          paddr_nxt = pg_r;
          pord_nxt  = ord_r;
          pret_nxt  = S_F_FIN;
          state_nxt = S_P_WR;
        end
      end
      S_F_BUD: begin
        // Merge only with a listed buddy of the same order.
        if (rword.on_list && (rword.ord == ord_r)) begin
          uaddr_nxt = bud_r;
          uret_nxt  = S_F_MERGE;
          state_nxt = S_U_RD;
        end else begin
          paddr_nxt = pg_r;
          pord_nxt  = ord_r;
          pret_nxt  = S_F_FIN;
          state_nxt = S_P_WR;
        end
      end
      S_F_MERGE: begin
        if (bud_r < pg_r) begin
          pg_nxt = bud_r;
        end
        ord_nxt   = ord_r + ORD_W'(1);
        state_nxt = S_F_LOOP;
      end
      S_F_FIN: begin
        rsp_nxt.result_offset = '0;
        rsp_nxt.status        = 1'b0;
        state_nxt             = S_DONE;
      end
      S_U_RD: begin
        ram_raddr = uaddr_r;
        state_nxt = S_U_W;
      end
      S_U_W: begin
        if (!rword.on_list) begin
          state_nxt = uret_r;
        end else begin
          up_nxt    = rword.prev;
          un_nxt    = rword.next;
          uord_nxt  = rword.ord;
          state_nxt = S_U_P;
        end
      end
      S_U_P: begin
        if (up_r < NIL) begin
          maddr_nxt = up_r[PG_W-1:0];
          mfld_nxt  = FLD_NEXT;
          mval_nxt  = un_r;
          mret_nxt  = S_U_N;
          state_nxt = S_M_RD;
        end else begin
          if (uord_r < ORD_W'(NUM_ORDERS)) begin
            head_nxt[uord_r] = un_r;
          end
          state_nxt = S_U_N;
        end
      end
      S_U_N: begin
        if (un_r < NIL) begin
          maddr_nxt = un_r[PG_W-1:0];
          mfld_nxt  = FLD_PREV;
          mval_nxt  = up_r;
          mret_nxt  = S_U_CLR;
          state_nxt = S_M_RD;
        end else begin
          state_nxt = S_U_CLR;
        end
      end
      S_U_CLR: begin
        ram_we            = 1'b1;
        ram_waddr         = uaddr_r;
        ram_wdata.on_list = 1'b0;
        ram_wdata.ord     = uord_r;
        ram_wdata.prev    = NIL;
        ram_wdata.next    = NIL;
        state_nxt         = uret_r;
      end
      S_P_WR: begin
        // Link the page in front of the old head of its list.
        ph_nxt            = head_r[pord_r];
        ram_we            = 1'b1;
        ram_waddr         = paddr_r;
        ram_wdata.on_list = 1'b1;
        ram_wdata.ord     = pord_r;
        ram_wdata.prev    = NIL;
        ram_wdata.next    = head_r[pord_r];
        head_nxt[pord_r]  = {1'b0, paddr_r};
        state_nxt         = S_P_H;
      end
      S_P_H: begin
        if (ph_r < NIL) begin
          maddr_nxt = ph_r[PG_W-1:0];
          mfld_nxt  = FLD_PREV;
          mval_nxt  = {1'b0, paddr_r};
          mret_nxt  = pret_r;
          state_nxt = S_M_RD;
        end else begin
          state_nxt = pret_r;
        end
      end
      S_M_RD: begin
        ram_raddr = maddr_r;
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        ram_we    = 1'b1;
        ram_waddr = maddr_r;
        ram_wdata = mword;
        state_nxt = mret_r;
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, list heads and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        head_r[k] <= (k == TOP_ORDER) ? '0 : NIL;
      end
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Working registers and read qualifiers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pg_r       <= pg_nxt;
    ord_r      <= ord_nxt;
    bud_r      <= bud_nxt;
    uaddr_r    <= uaddr_nxt;
    up_r       <= up_nxt;
    un_r       <= un_nxt;
    uord_r     <= uord_nxt;
    uret_r     <= uret_nxt;
    paddr_r    <= paddr_nxt;
    pord_r     <= pord_nxt;
    ph_r       <= ph_nxt;
    pret_r     <= pret_nxt;
    maddr_r    <= maddr_nxt;
    mfld_r     <= mfld_nxt;
    mval_r     <= mval_nxt;
    mret_r     <= mret_nxt;
    rsp_r      <= rsp_nxt;
    rd_valid_r <= valid_r[ram_raddr];
    rd_zero_r  <= (ram_raddr == '0);
  end

  `BBA_ASSERT_NEXT(a_done_idle, done, state_r == S_IDLE, "engine not idle after result")
  `BBA_ASSERT(a_fail_zero, !(done && rsp_r.status) || (rsp_r.result_offset == '0), "fail offset")
  `BBA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "engine took two requests")

endmodule

### hw/rtl/buddy_block_allocator_top.sv
// Buddy block allocator: a 1 MiB pool of 4 KiB pages, blocks of 4 KiB to 1 MiB.
// Usage:
//   The input stream carries one request per transfer: in_tuser selects allocate
//   (0) or free (1); in_tdata holds the byte size and the byte offset to free.
//   Every request yields exactly one result on the output stream: out_tdata holds
//   the allocated byte offset (zero on failure and for a free), out_tuser is set
//   when no free block was large enough.
//   Requests are handled one at a time; in_tready is low while one is in work.
//   The time to a result is set by the page link memory, which the sequencer
//   accesses at most once per state; on it each list unlink, push and buddy
//   check is a short chain of read-modify-writes, repeated once per split or
//   merge level.
//   The result waits in an output register; the next request is accepted while it
//   waits, but its own result is held back until the receiver takes the first.
//   Reset makes the whole pool one free block at page 0 at once; per-page valid
//   bits stand in for the link memory until each page is first written, so no
//   clearing pass is run.
// Depends on bba_pkg and bba_engine.
module buddy_block_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // request_size [20:0], block_offset [40:21], zeros
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_offset [19:0], zeros
  output logic        out_tuser   // status
);
  import bba_pkg::*;

  bba_req_t req;
  bba_rsp_t rsp;
  logic     done;
  logic     out_free;
  logic     out_valid_r;
  bba_rsp_t out_rsp_r;

  assign req.operation    = in_tuser;
  assign req.request_size = in_tdata[SIZE_W-1:0];
  assign req.block_offset = in_tdata[SIZE_W+POOL_BITS-1:SIZE_W];

  assign out_free = !out_valid_r || out_tready;

  bba_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .req      (req),
    .out_free (out_free),
    .done     (done),
    .rsp      (rsp)
  );

  // Output register toward the result stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - POOL_BITS){1'b0}}, out_rsp_r.result_offset};
  assign out_tuser  = out_rsp_r.status;

endmodule
